// ===== rtl/core/hfn_pkg.sv =====
// Package for the raster hole filler: image size, coordinate width and the
// per-pixel position record shared by the counter and the top level.
// No dependencies.
`default_nettype none

package hfn_pkg;

    localparam int ImageSize = 256;
    localparam int CoordW    = (ImageSize > 1) ? $clog2(ImageSize) : 1;
    localparam int PixelW    = 32;

    typedef logic [CoordW-1:0] coord_t;
    typedef logic [PixelW-1:0] pixel_t;

    // Position of one pixel in the frame, decoded from the raster counters
    typedef struct packed {
        coord_t col;
        logic   inner;
        logic   last;
    } pos_t;

endpackage

`default_nettype wire

// ===== rtl/core/hfn_line_buf.sv =====
// Line buffer of processed pixels, one entry per column.
// One write port, one read port with registered data. Depends on hfn_pkg.
`default_nettype none

module hfn_line_buf (
    input  wire logic           aclk,
    input  wire logic           rd_en,
    input  wire hfn_pkg::coord_t rd_addr,
    output hfn_pkg::pixel_t     rd_data,
    input  wire logic           wr_en,
    input  wire hfn_pkg::coord_t wr_addr,
    input  wire hfn_pkg::pixel_t wr_data
);
    import hfn_pkg::*;

    pixel_t mem [ImageSize];
    pixel_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hfn_raster_ctr.sv =====
// Row and column counters for the incoming raster, with frame restart and
// wrap, and decode of border and last-pixel flags. Depends on hfn_pkg.
`default_nettype none

module hfn_raster_ctr (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic        frame_start,
    output hfn_pkg::pos_t    pos
);
    import hfn_pkg::*;

    localparam coord_t LastCoord = CoordW'(ImageSize - 1);
    localparam coord_t Zero      = '0;

    coord_t col_reg, col_next;
    coord_t row_reg, row_next;
    coord_t col, row;

    // A frame start puts this pixel at the origin
    assign col = frame_start ? Zero : col_reg;
    assign row = frame_start ? Zero : row_reg;

    always_comb begin
        pos.col   = col;
        pos.inner = (row != Zero) && (row != LastCoord) &&
                    (col != Zero) && (col != LastCoord);
        pos.last  = (row == LastCoord) && (col == LastCoord);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col == LastCoord) begin
                col_next = Zero;
                row_next = (row == LastCoord) ? Zero : row + CoordW'(1);
            end else begin
                col_next = col + CoordW'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/raster_hole_fill_from_neighbours_unit.sv =====
// Raster hole filler, top level. An input transfer passes through the stage
// register and then the output register to m_tvalid; throughput: one pixel per
// cycle while the output is not stalled, set by one line buffer read at input
// transfer and one write as the stage advances, on separate ports.
// Reset (aresetn, synchronous, active low) clears the counters, the left
// pixel, the transparent color and the valid flags; the line buffer is not
// cleared, row 0 of each frame fills it before it is read.
// Depends on hfn_pkg, hfn_raster_ctr and hfn_line_buf.
`default_nettype none

module raster_hole_fill_from_neighbours_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_wdata,    // transparent_color
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire hfn_pkg::pixel_t     s_tdata,      // [31:0] pixel_in
    input  wire logic [0:0]          s_tuser,      // [0] frame_start
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output hfn_pkg::pixel_t          m_tdata,      // [31:0] pixel_out
    output logic                     m_tlast       // frame_end
);
    import hfn_pkg::*;

    logic   s_xfer;
    logic   advance;
    pos_t   in_pos;
    pixel_t above_q;
    pixel_t result;

    pixel_t tc_reg;
    logic   st_valid_reg, st_valid_next;
    pixel_t st_pix_reg;
    pos_t   st_pos_reg;
    pixel_t left_reg;
    logic   out_valid_reg, out_valid_next;
    pixel_t out_data_reg;
    logic   out_last_reg;

    // Stage advances when its result can move into the output register
    assign advance  = st_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    hfn_raster_ctr u_ctr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_xfer),
        .frame_start (s_tuser[0]),
        .pos         (in_pos)
    );

    hfn_line_buf u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_xfer),
        .rd_addr (in_pos.col),
        .rd_data (above_q),
        .wr_en   (advance),
        .wr_addr (st_pos_reg.col),
        .wr_data (result)
    );

    // Fill an inner hole from above, or from the left when above is a hole too
    always_comb begin
        result = st_pix_reg;
        if (st_pos_reg.inner && (st_pix_reg == tc_reg)) begin
            result = (above_q == tc_reg) ? left_reg : above_q;
        end
    end

    assign st_valid_next  = s_xfer ? 1'b1 : (advance ? 1'b0 : st_valid_reg);
    assign out_valid_next = advance ? 1'b1 :
                            ((out_valid_reg && m_tready) ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg        <= '0;
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end else begin
            if (cfg_we) begin
                tc_reg <= cfg_wdata;
            end
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                left_reg <= result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            st_pix_reg <= s_tdata;
            st_pos_reg <= in_pos;
        end
        if (advance) begin
            out_data_reg <= result;
            out_last_reg <= st_pos_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Input back-pressure only comes from a full stage
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> st_valid_reg)
        else $error("s_tready low with empty stage");

    // An input transfer always lands in the stage
    a_xfer_loads_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> st_valid_reg)
        else $error("accepted pixel lost");

    // Full stage behind a stalled output must block the input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && st_valid_reg) |-> !s_tready)
        else $error("input accepted while pipeline full");

    // A stage that advances produces a valid result next cycle
    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced result not presented");

endmodule

`default_nettype wire
